// ----- hw/rtl/brs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package brs_pkg;

    // Configuration register index; one spare bit, and writes to out-of-range indices are ignored
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_AREA_LEFT   = 3'd0,
        REG_AREA_TOP    = 3'd1,
        REG_AREA_RIGHT  = 3'd2,
        REG_AREA_BOTTOM = 3'd3
    } t_reg_idx;

    localparam int AREA_LEFT_RST   = 0;
    localparam int AREA_TOP_RST    = 0;
    localparam int AREA_RIGHT_RST  = 1920;
    localparam int AREA_BOTTOM_RST = 1080;

    localparam int DIR_BITS = 3;

    typedef enum logic [DIR_BITS-1:0] {
        DIR_NONE  = 3'd0,
        DIR_NORTH = 3'd1,
        DIR_WEST  = 3'd2,
        DIR_SOUTH = 3'd3,
        DIR_EAST  = 3'd4
    } t_dir;

    // Candidate slot index, north first
    localparam int NUM_CAND = 4;
    typedef logic [1:0] t_cand;

    localparam t_cand CAND_NORTH = 2'd0;
    localparam t_cand CAND_WEST  = 2'd1;
    localparam t_cand CAND_SOUTH = 2'd2;
    localparam t_cand CAND_EAST  = 2'd3;

    // Extra bits on internal sums so nothing wraps
    localparam int EXT_BITS = 3;

endpackage

`default_nettype wire

// ----- hw/rtl/brs_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface brs_req_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] box_left;
    logic signed [COORD_BITS-1:0] box_top;
    logic signed [COORD_BITS-1:0] box_right;
    logic signed [COORD_BITS-1:0] box_bottom;
    logic signed [COORD_BITS-1:0] busy_left;
    logic signed [COORD_BITS-1:0] busy_top;
    logic signed [COORD_BITS-1:0] busy_right;
    logic signed [COORD_BITS-1:0] busy_bottom;
    logic [2:0]                   first_dir;

    modport source (
        output valid, box_left, box_top, box_right, box_bottom,
               busy_left, busy_top, busy_right, busy_bottom, first_dir,
        input  ready
    );
    modport sink (
        input  valid, box_left, box_top, box_right, box_bottom,
               busy_left, busy_top, busy_right, busy_bottom, first_dir,
        output ready
    );
endinterface

interface brs_rsp_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   chosen_dir;
    logic signed [COORD_BITS-1:0] new_left;
    logic signed [COORD_BITS-1:0] new_top;
    logic signed [COORD_BITS-1:0] new_right;
    logic signed [COORD_BITS-1:0] new_bottom;

    modport source (
        output valid, chosen_dir, new_left, new_top, new_right, new_bottom,
        input  ready
    );
    modport sink (
        input  valid, chosen_dir, new_left, new_top, new_right, new_bottom,
        output ready
    );
endinterface

interface brs_cfg_if #(
    parameter int DATA_BITS = 16,
    parameter int IDX_BITS  = 3
);
    logic                 valid;
    logic                 ready;
    logic [IDX_BITS-1:0]  index;
    logic [DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input  valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/box_relocation_search_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Finds a free slot for a box beside an occupied region, inside a work area
// held in four configuration registers. A request beat is taken every cycle
// while the pipeline is not held by a stalled response side; each result
// passes an input register, four compute stages and an output register.
// Throughput is one beat per clock when the response side does not stall, set
// by the fully pipelined path: widths, clamp limits, clamped candidates, four
// parallel slot checks, then a rotating priority pick. Stages hold
// independently, so bubbles collapse while the output waits. Write the area
// registers only while no request is in flight.
module box_relocation_search_top
    import brs_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    brs_cfg_if.sink     i_cfg,
    brs_req_if.sink     i_req,
    brs_rsp_if.source   o_rsp
);
    localparam int W  = COORD_BITS;
    localparam int WX = COORD_BITS + EXT_BITS;
    localparam int NS = 6;

    typedef logic signed [WX-1:0] t_x;

    function automatic t_x sx(input logic signed [W-1:0] v);
        return WX'(v);
    endfunction

    // configuration
    logic signed [W-1:0] r_area_left, r_area_top, r_area_right, r_area_bottom;
    t_x al, at, ar, ab;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_left   <= W'(AREA_LEFT_RST);
            r_area_top    <= W'(AREA_TOP_RST);
            r_area_right  <= W'(AREA_RIGHT_RST);
            r_area_bottom <= W'(AREA_BOTTOM_RST);
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_AREA_LEFT:   r_area_left   <= i_cfg.data;
                REG_AREA_TOP:    r_area_top    <= i_cfg.data;
                REG_AREA_RIGHT:  r_area_right  <= i_cfg.data;
                REG_AREA_BOTTOM: r_area_bottom <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign al = sx(r_area_left);
    assign at = sx(r_area_top);
    assign ar = sx(r_area_right);
    assign ab = sx(r_area_bottom);

    // stage valids and hold logic
    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || o_rsp.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
        n_v[0] = w_en[0] ? i_req.valid : r_v[0];
        for (int k = 1; k < NS; k++) begin
            n_v[k] = w_en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign i_req.ready = w_en[0];

    // stage 0: input register
    t_x    r0_bl, r0_bt, r0_br, r0_bb, r0_ol, r0_ot, r0_or, r0_ob;
    t_cand r0_first;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_bl <= sx(i_req.box_left);
            r0_bt <= sx(i_req.box_top);
            r0_br <= sx(i_req.box_right);
            r0_bb <= sx(i_req.box_bottom);
            r0_ol <= sx(i_req.busy_left);
            r0_ot <= sx(i_req.busy_top);
            r0_or <= sx(i_req.busy_right);
            r0_ob <= sx(i_req.busy_bottom);
            // unknown codes start at north
            if (i_req.first_dir >= DIR_NORTH && i_req.first_dir <= DIR_EAST) begin
                r0_first <= t_cand'(i_req.first_dir - 3'd1);
            end else begin
                r0_first <= CAND_NORTH;
            end
        end
    end

    // stage 1: box size and reject test
    t_x    s1_w, s1_h;
    t_x    r1_w, r1_h, r1_bl, r1_bt, r1_ol, r1_ot, r1_or, r1_ob;
    t_cand r1_first;
    logic  r1_reject;

    assign s1_w = r0_br - r0_bl;
    assign s1_h = r0_bb - r0_bt;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_w      <= s1_w;
            r1_h      <= s1_h;
            r1_reject <= (s1_w <= t_x'(0)) || (s1_h <= t_x'(0))
                         || (s1_w > ar - al) || (s1_h > ab - at);
            r1_bl     <= r0_bl;
            r1_bt     <= r0_bt;
            r1_ol     <= r0_ol;
            r1_ot     <= r0_ot;
            r1_or     <= r0_or;
            r1_ob     <= r0_ob;
            r1_first  <= r0_first;
        end
    end

    // stage 2: clamp limits and the busy-relative edges
    t_x    r2_hix, r2_hiy, r2_cy_n, r2_cx_w;
    t_x    r2_w, r2_h, r2_bl, r2_bt, r2_ol, r2_ot, r2_or, r2_ob;
    t_cand r2_first;
    logic  r2_reject;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_hix    <= ar - r1_w;
            r2_hiy    <= ab - r1_h;
            r2_cy_n   <= r1_ot - r1_h;
            r2_cx_w   <= r1_ol - r1_w;
            r2_w      <= r1_w;
            r2_h      <= r1_h;
            r2_bl     <= r1_bl;
            r2_bt     <= r1_bt;
            r2_ol     <= r1_ol;
            r2_ot     <= r1_ot;
            r2_or     <= r1_or;
            r2_ob     <= r1_ob;
            r2_first  <= r1_first;
            r2_reject <= r1_reject;
        end
    end

    // stage 3: clamp the kept axis and form the four candidates
    t_x    s3_kx, s3_ky;
    t_x    r3_cx [NUM_CAND];
    t_x    r3_cy [NUM_CAND];
    t_x    r3_w, r3_h, r3_ol, r3_ot, r3_or, r3_ob;
    t_cand r3_first;
    logic  r3_reject;

    always_comb begin
        if (r2_bl < al) begin
            s3_kx = al;
        end else if (r2_bl > r2_hix) begin
            s3_kx = r2_hix;
        end else begin
            s3_kx = r2_bl;
        end
        if (r2_bt < at) begin
            s3_ky = at;
        end else if (r2_bt > r2_hiy) begin
            s3_ky = r2_hiy;
        end else begin
            s3_ky = r2_bt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_cx[CAND_NORTH] <= s3_kx;
            r3_cy[CAND_NORTH] <= r2_cy_n;
            r3_cx[CAND_WEST]  <= r2_cx_w;
            r3_cy[CAND_WEST]  <= s3_ky;
            r3_cx[CAND_SOUTH] <= s3_kx;
            r3_cy[CAND_SOUTH] <= r2_ob;
            r3_cx[CAND_EAST]  <= r2_or;
            r3_cy[CAND_EAST]  <= s3_ky;
            r3_w      <= r2_w;
            r3_h      <= r2_h;
            r3_ol     <= r2_ol;
            r3_ot     <= r2_ot;
            r3_or     <= r2_or;
            r3_ob     <= r2_ob;
            r3_first  <= r2_first;
            r3_reject <= r2_reject;
        end
    end

    // stage 4: check all four slots in parallel
    t_x              s4_sr [NUM_CAND];
    t_x              s4_sb [NUM_CAND];
    logic [NUM_CAND-1:0] s4_ok;
    t_x              r4_sl [NUM_CAND];
    t_x              r4_st [NUM_CAND];
    t_x              r4_sr [NUM_CAND];
    t_x              r4_sb [NUM_CAND];
    logic [NUM_CAND-1:0] r4_ok;
    t_cand           r4_first;

    for (genvar g = 0; g < NUM_CAND; g++) begin : g_chk
        brs_slot_chk #(
            .WX (WX)
        ) u_chk (
            .i_sl (r3_cx[g]),
            .i_st (r3_cy[g]),
            .i_w  (r3_w),
            .i_h  (r3_h),
            .i_al (al),
            .i_at (at),
            .i_ar (ar),
            .i_ab (ab),
            .i_ol (r3_ol),
            .i_ot (r3_ot),
            .i_or (r3_or),
            .i_ob (r3_ob),
            .o_sr (s4_sr[g]),
            .o_sb (s4_sb[g]),
            .o_ok (s4_ok[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int k = 0; k < NUM_CAND; k++) begin
                r4_sl[k] <= r3_cx[k];
                r4_st[k] <= r3_cy[k];
                r4_sr[k] <= s4_sr[k];
                r4_sb[k] <= s4_sb[k];
            end
            // a rejected box finds nothing
            r4_ok    <= r3_reject ? '0 : s4_ok;
            r4_first <= r3_first;
        end
    end

    // stage 5: rotating priority pick into the output register
    t_cand s5_sel;
    logic  s5_found;
    t_cand s5_idx;

    always_comb begin
        s5_sel   = CAND_NORTH;
        s5_found = 1'b0;
        for (int n = 0; n < NUM_CAND; n++) begin
            s5_idx = r4_first + t_cand'(n);
            if (!s5_found && r4_ok[s5_idx]) begin
                s5_found = 1'b1;
                s5_sel   = s5_idx;
            end
        end
    end

    logic [DIR_BITS-1:0] r_dir;
    logic signed [W-1:0] r_new_left, r_new_top, r_new_right, r_new_bottom;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            if (s5_found) begin
                r_dir        <= DIR_BITS'(s5_sel) + DIR_BITS'(1);
                r_new_left   <= r4_sl[s5_sel][W-1:0];
                r_new_top    <= r4_st[s5_sel][W-1:0];
                r_new_right  <= r4_sr[s5_sel][W-1:0];
                r_new_bottom <= r4_sb[s5_sel][W-1:0];
            end else begin
                r_dir        <= DIR_NONE;
                r_new_left   <= '0;
                r_new_top    <= '0;
                r_new_right  <= '0;
                r_new_bottom <= '0;
            end
        end
    end

    assign o_rsp.valid      = r_v[NS-1];
    assign o_rsp.chosen_dir = r_dir;
    assign o_rsp.new_left   = r_new_left;
    assign o_rsp.new_top    = r_new_top;
    assign o_rsp.new_right  = r_new_right;
    assign o_rsp.new_bottom = r_new_bottom;

    // no slot means an all-zero box
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-1] && r_dir == DIR_NONE |->
            r_new_left == '0 && r_new_top == '0 && r_new_right == '0 && r_new_bottom == '0)
        else $error("empty result carries nonzero box");

    // a chosen slot is never empty
    a_slot_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-1] && r_dir != DIR_NONE |->
            r_new_left < r_new_right && r_new_top < r_new_bottom)
        else $error("chosen slot is empty");

    // a held check stage keeps its beat and its verdicts
    a_hold_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] && !w_en[4] |=> r_v[4] && $stable(r4_ok) && $stable(r4_first))
        else $error("check stage lost a held beat");

    // a rejected box never reaches a candidate verdict
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] && w_en[4] && r3_reject |=> r4_ok == '0)
        else $error("rejected box produced a slot");

endmodule

`default_nettype wire

// ----- hw/rtl/brs_slot_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brs_slot_chk #(
    parameter int WX = 19
) (
    input  wire logic signed [WX-1:0] i_sl,
    input  wire logic signed [WX-1:0] i_st,
    input  wire logic signed [WX-1:0] i_w,
    input  wire logic signed [WX-1:0] i_h,
    input  wire logic signed [WX-1:0] i_al,
    input  wire logic signed [WX-1:0] i_at,
    input  wire logic signed [WX-1:0] i_ar,
    input  wire logic signed [WX-1:0] i_ab,
    input  wire logic signed [WX-1:0] i_ol,
    input  wire logic signed [WX-1:0] i_ot,
    input  wire logic signed [WX-1:0] i_or,
    input  wire logic signed [WX-1:0] i_ob,
    output logic signed [WX-1:0]      o_sr,
    output logic signed [WX-1:0]      o_sb,
    output logic                      o_ok
);
    logic in_area;
    logic overlap;

    always_comb begin
        o_sr    = i_sl + i_w;
        o_sb    = i_st + i_h;
        in_area = !(i_sl < i_al || i_st < i_at || o_sr > i_ar || o_sb > i_ab);
        // touching edges are not overlap
        overlap = (i_sl < i_or) && (i_ol < o_sr) && (i_st < i_ob) && (i_ot < o_sb);
        o_ok    = in_area && !overlap;
    end

endmodule

`default_nettype wire
